[sv/ssplit_pkg.sv]
`timescale 1ns / 1ps

package ssplit_pkg;

  // Character codes the lexer reacts to.
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Request codes of the input word.
  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_END  = 1'b1;

  typedef enum logic [3:0] {
    MODE_PLAIN = 4'd0,
    MODE_DASH  = 4'd1,
    MODE_SLASH = 4'd2,
    MODE_DOL   = 4'd3,
    MODE_DD    = 4'd4,
    MODE_DDD   = 4'd5,
    MODE_LINE  = 4'd6,
    MODE_BLOCK = 4'd7,
    MODE_BSTAR = 4'd8,
    MODE_QUOTE = 4'd9
  } lex_mode_t;

  typedef struct packed {
    lex_mode_t mode;
    logic      quote_is_double;
    logic      escape_pending;
    logic      stmt_has_text;
    logic      stmt_has_any;
  } lex_state_t;

  localparam lex_state_t STATE_RESET = '{
    mode:            MODE_PLAIN,
    quote_is_double: 1'b0,
    escape_pending:  1'b0,
    stmt_has_text:   1'b0,
    stmt_has_any:    1'b0
  };

  typedef struct packed {
    logic       char_valid;
    logic [7:0] out_char;
    logic       is_space;
    logic       stmt_end;
    logic       stmt_nonempty;
    logic       last;
  } result_t;

  // Up to two output words produced by one input word.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } result_pair_t;

  function automatic logic space_of(input logic [7:0] c);
    logic s;
    case (c) inside
      [8'd9:8'd13], 8'd32, 8'd133, 8'd160: s = 1'b1;
      default:                             s = 1'b0;
    endcase
    return s;
  endfunction

  function automatic result_t char_word(input logic [7:0] c);
    result_t r;
    r               = '0;
    r.char_valid    = 1'b1;
    r.out_char      = c;
    r.is_space      = space_of(c);
    return r;
  endfunction

  function automatic result_t end_word(input logic nonempty);
    result_t r;
    r               = '0;
    r.stmt_end      = 1'b1;
    r.stmt_nonempty = nonempty;
    return r;
  endfunction

endpackage

[sv/ssplit_if.sv]
`timescale 1ns / 1ps

interface ssplit_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_code;

  modport source (output valid, output req_type, output char_code, input ready);
  modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

interface ssplit_out_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [7:0] out_char;
  logic       is_space;
  logic       stmt_end;
  logic       stmt_nonempty;
  logic       last;

  modport source (output valid, output char_valid, output out_char, output is_space,
                  output stmt_end, output stmt_nonempty, output last, input ready);
  modport sink   (input valid, input char_valid, input out_char, input is_space,
                  input stmt_end, input stmt_nonempty, input last, output ready);
endinterface

[sv/ssplit_lexer.sv]
`timescale 1ns / 1ps

module ssplit_lexer (
  input  ssplit_pkg::lex_state_t   st,
  input  logic                     req_type,
  input  logic [7:0]               char_code,
  output ssplit_pkg::lex_state_t   st_next,
  output logic                     res_any,
  output ssplit_pkg::result_pair_t res
);
  import ssplit_pkg::*;

  logic c_space;

  assign c_space = space_of(char_code);

  // Next state.
  always_comb begin
    st_next = st;
    if (req_type == REQ_END) begin
      st_next = STATE_RESET;
    end else begin
      case (st.mode)
        MODE_DASH: begin
          if (char_code == CH_DASH) begin
            st_next.mode = MODE_LINE;
          end else begin
            st_next.mode          = MODE_PLAIN;
            st_next.stmt_has_any  = 1'b1;
            st_next.stmt_has_text = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (char_code == CH_STAR) begin
            st_next.mode = MODE_BLOCK;
          end else begin
            st_next.mode          = MODE_PLAIN;
            st_next.stmt_has_any  = 1'b1;
            st_next.stmt_has_text = 1'b1;
          end
        end
        MODE_DOL, MODE_DD, MODE_DDD: begin
          st_next.stmt_has_any = 1'b1;
          if (!c_space) st_next.stmt_has_text = 1'b1;
          if (st.mode == MODE_DOL) begin
            st_next.mode = (char_code == CH_DOLLAR) ? MODE_DD : MODE_PLAIN;
          end else if (st.mode == MODE_DD) begin
            if (char_code == CH_DOLLAR) st_next.mode = MODE_DDD;
          end else begin
            st_next.mode = (char_code == CH_DOLLAR) ? MODE_PLAIN : MODE_DD;
          end
        end
        MODE_LINE: begin
          if (char_code == CH_NL) begin
            st_next.stmt_has_any = 1'b1;
            st_next.mode         = MODE_PLAIN;
          end
        end
        MODE_BLOCK: begin
          if (char_code == CH_STAR) st_next.mode = MODE_BSTAR;
        end
        MODE_BSTAR: begin
          if (char_code == CH_SLASH) begin
            st_next.mode = MODE_PLAIN;
          end else if (char_code != CH_STAR) begin
            st_next.mode = MODE_BLOCK;
          end
        end
        MODE_QUOTE: begin
          st_next.stmt_has_any = 1'b1;
          if (!c_space) st_next.stmt_has_text = 1'b1;
          if (st.escape_pending) begin
            st_next.escape_pending = 1'b0;
          end else if (char_code == CH_BSLASH) begin
            st_next.escape_pending = 1'b1;
          end else if (char_code == (st.quote_is_double ? CH_DQUOTE : CH_SQUOTE)) begin
            st_next.mode = MODE_PLAIN;
          end
        end
        default: begin
          // Plain text; unreachable codes behave the same way.
          if (char_code == CH_DASH) begin
            st_next.mode = MODE_DASH;
          end else if (char_code == CH_SLASH) begin
            st_next.mode = MODE_SLASH;
          end else if (char_code == CH_SEMI) begin
            st_next.mode          = MODE_PLAIN;
            st_next.stmt_has_text = 1'b0;
            st_next.stmt_has_any  = 1'b0;
          end else begin
            st_next.mode         = MODE_PLAIN;
            st_next.stmt_has_any = 1'b1;
            if (!c_space) st_next.stmt_has_text = 1'b1;
            if (char_code == CH_SQUOTE || char_code == CH_DQUOTE) begin
              st_next.mode            = MODE_QUOTE;
              st_next.quote_is_double = (char_code == CH_DQUOTE);
              st_next.escape_pending  = 1'b0;
            end else if (char_code == CH_DOLLAR) begin
              st_next.mode = MODE_DOL;
            end
          end
        end
      endcase
    end
  end

  // Output words.
  always_comb begin
    res     = '0;
    res_any = 1'b0;
    if (req_type == REQ_END) begin
      res_any = 1'b1;
      if (st.mode == MODE_DASH || st.mode == MODE_SLASH) begin
        res.two = 1'b1;
        res.r0  = char_word((st.mode == MODE_DASH) ? CH_DASH : CH_SLASH);
        res.r1  = end_word(1'b1);
      end else begin
        res.r0 = end_word(st.stmt_has_any);
      end
    end else begin
      case (st.mode)
        MODE_DASH: begin
          if (char_code != CH_DASH) begin
            res_any = 1'b1;
            res.two = 1'b1;
            res.r0  = char_word(CH_DASH);
            res.r1  = char_word(char_code);
          end
        end
        MODE_SLASH: begin
          if (char_code != CH_STAR) begin
            res_any = 1'b1;
            res.two = 1'b1;
            res.r0  = char_word(CH_SLASH);
            res.r1  = char_word(char_code);
          end
        end
        MODE_DOL, MODE_DD, MODE_DDD, MODE_QUOTE: begin
          res_any = 1'b1;
          res.r0  = char_word(char_code);
        end
        MODE_LINE: begin
          if (char_code == CH_NL) begin
            res_any = 1'b1;
            res.r0  = char_word(char_code);
          end
        end
        MODE_BLOCK, MODE_BSTAR: begin
          res_any = 1'b0;
        end
        default: begin
          if (char_code == CH_SEMI) begin
            res_any = 1'b1;
            res.r0  = end_word(st.stmt_has_text);
          end else if (char_code != CH_DASH && char_code != CH_SLASH) begin
            res_any = 1'b1;
            res.r0  = char_word(char_code);
          end
        end
      endcase
    end
    // The final word of this input word carries the last mark.
    if (res.two) begin
      res.r1.last = 1'b1;
    end else begin
      res.r0.last = res_any;
    end
  end

endmodule

[sv/sql_statement_splitter.sv]
`timescale 1ns / 1ps

// SQL statement splitter.
// The in_ch channel takes one word per character of SQL text (req_type 0,
// char_code holds the byte) or an end-of-text mark (req_type 1). The out_ch
// channel gives kept characters with a per-byte whitespace flag, and boundary
// words (stmt_end) that close a statement at a semicolon in plain text or at
// end of text; last marks the final output word caused by one input word.
// Comments are stripped; a held '-' or '/' is released with the next word.
// An accepted word is held in the input register and lexed there; its
// results go to the output queue, which shows its first output word; a
// second output word, when there is one, follows once the receiver takes one.
// Throughput: one input word per cycle while the receiver does not stall and
// each input word gives at most one output word; the lexer state and the
// two-entry output queue set that figure, and a word that gives two outputs holds its entry until both are taken.
// A stalled receiver fills the output queue (two input words' results), then
// the input register holds its word and in_ch.ready drops; nothing is lost.
// Reset (rst, synchronous) returns the lexer to plain text with an empty
// statement, and empties the input register and output queue.
module sql_statement_splitter (
  input  logic                clk,
  input  logic                rst,
  ssplit_in_if.sink           in_ch,
  ssplit_out_if.source        out_ch
);
  import ssplit_pkg::*;

  // Input register.
  logic       hold_valid;
  logic       hold_req;
  logic [7:0] hold_char;

  // Lexer state.
  lex_state_t st;
  lex_state_t st_next;

  // Lexer results for the word in the input register.
  logic         res_any;
  result_pair_t res;

  // Output queue: each entry is all output words of one input word.
  result_pair_t queue [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   q_count;
  logic         sub;           // 1 while the second word of the head entry is shown

  logic         process;
  logic         push;
  logic         pop;
  logic         in_accept;
  logic         out_accept;
  result_pair_t head;
  result_t      head_word;

  ssplit_lexer u_lexer (
    .st        (st),
    .req_type  (hold_req),
    .char_code (hold_char),
    .st_next   (st_next),
    .res_any   (res_any),
    .res       (res)
  );

  // The held word is lexed once the queue has room for its results.
  assign process   = hold_valid && (q_count != 2'd2);
  assign push      = process && res_any;
  assign in_accept = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !hold_valid || process;

  assign head       = queue[rd_ptr];
  assign head_word  = sub ? head.r1 : head.r0;
  assign out_accept = out_ch.valid && out_ch.ready;
  assign pop        = out_accept && !(head.two && !sub);

  assign out_ch.valid         = (q_count != 2'd0);
  assign out_ch.char_valid    = head_word.char_valid;
  assign out_ch.out_char      = head_word.out_char;
  assign out_ch.is_space      = head_word.is_space;
  assign out_ch.stmt_end      = head_word.stmt_end;
  assign out_ch.stmt_nonempty = head_word.stmt_nonempty;
  assign out_ch.last          = head_word.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      st         <= STATE_RESET;
      wr_ptr     <= 1'b0;
      rd_ptr     <= 1'b0;
      q_count    <= 2'd0;
      sub        <= 1'b0;
    end else begin
      if (in_accept) begin
        hold_valid <= 1'b1;
      end else if (process) begin
        hold_valid <= 1'b0;
      end
      if (process) begin
        st <= st_next;
      end
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (out_accept) begin
        if (pop) begin
          rd_ptr <= ~rd_ptr;
          sub    <= 1'b0;
        end else begin
          sub <= 1'b1;
        end
      end
      q_count <= q_count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      hold_req  <= in_ch.req_type;
      hold_char <= in_ch.char_code;
    end
    if (push) begin
      queue[wr_ptr] <= res;
    end
  end

endmodule
